@@ design/sixbq_pkg.sv @@
// shared types and constants for the six-axis biquad cascade filter
// no dependencies
package sixbq_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 24;
  localparam int COEF_FRAC   = 20;
  localparam int DATA_FRAC   = 8;
  localparam int DATA_BITS   = SAMPLE_BITS + DATA_FRAC;
  localparam int IN_CHANNELS = 6;
  localparam int CH_W        = 3;
  localparam int TAPS        = 5;
  localparam int TAP_W       = 3;
  localparam int NSEC_BITS   = 3;
  localparam int OPC_W       = 2;
  localparam int CIDX_W      = 5;

  localparam logic [OPC_W-1:0] OP_FILT = 2'd0;
  localparam logic [OPC_W-1:0] OP_COEF = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLR  = 2'd2;

  localparam logic [TAP_W-1:0] TAP_B0 = 3'd0;
  localparam logic [TAP_W-1:0] TAP_B1 = 3'd1;
  localparam logic [TAP_W-1:0] TAP_B2 = 3'd2;
  localparam logic [TAP_W-1:0] TAP_A1 = 3'd3;
  localparam logic [TAP_W-1:0] TAP_A2 = 3'd4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [DATA_BITS-1:0]   data_t;

  typedef struct packed {
    data_t x1;
    data_t x2;
    data_t y1;
    data_t y2;
  } hist_t;

endpackage

@@ design/sixbq_if.sv @@
// item channels of the six-axis biquad cascade filter
// depends on sixbq_pkg
interface sixbq_in_if;
  import sixbq_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPC_W-1:0]    opcode;
  sample_t             accel_x;
  sample_t             accel_y;
  sample_t             accel_z;
  sample_t             gyro_x;
  sample_t             gyro_y;
  sample_t             gyro_z;
  logic [CIDX_W-1:0]   coef_index;
  coef_t               coef_value;

  modport source (output valid, opcode, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  coef_index, coef_value, input ready);
  modport sink (input valid, opcode, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                coef_index, coef_value, output ready);
endinterface

interface sixbq_out_if;
  import sixbq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t filt_accel_x;
  sample_t filt_accel_y;
  sample_t filt_accel_z;
  sample_t filt_gyro_x;
  sample_t filt_gyro_y;
  sample_t filt_gyro_z;

  modport source (output valid, filt_accel_x, filt_accel_y, filt_accel_z, filt_gyro_x,
                  filt_gyro_y, filt_gyro_z, input ready);
  modport sink (input valid, filt_accel_x, filt_accel_y, filt_accel_z, filt_gyro_x,
                filt_gyro_y, filt_gyro_z, output ready);
endinterface

interface sixbq_cfg_if;
  import sixbq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [NSEC_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ design/six_axis_biquad_cascade_filter.sv @@
// six-axis cascaded direct-form-1 biquad filter, one shared multiply-accumulate
// depends on sixbq_pkg and the interfaces in sixbq_if
//
//   port      dir   carries
//   samples   sink  opcode, six samples, coef_index, coef_value
//   filtered  src   six filtered samples, one item per filter opcode
//   cfg       sink  num_sections, always ready
//
// each section is 5 tap reads, a drain of the multiply-accumulate pipeline and a history
// write
// coefficient and clear items are handled in the idle state; no clearing pass after reset
// a finished result waits in the output register; the next item is taken once it is loaded there
module six_axis_biquad_cascade_filter #(
  parameter int MAX_SECTIONS = 5,
  parameter int NUM_CHANNELS = 6
) (
  input logic         clk,
  input logic         rst,
  sixbq_in_if.sink    samples,
  sixbq_out_if.source filtered,
  sixbq_cfg_if.sink   cfg
);
  import sixbq_pkg::*;

  localparam int USED_CH   = (NUM_CHANNELS < IN_CHANNELS) ? NUM_CHANNELS : IN_CHANNELS;
  localparam int NUM_COEFS = MAX_SECTIONS * TAPS;
  localparam int CA_W      = $clog2(NUM_COEFS);
  localparam int NUM_ROWS  = USED_CH * MAX_SECTIONS;
  localparam int ROW_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int SEC_W     = $clog2(MAX_SECTIONS + 1);
  localparam int PROD_W    = COEF_BITS + DATA_BITS;
  localparam int ACC_W     = PROD_W + 3;
  localparam int RS_W      = ACC_W + 1;
  localparam int FO_W      = DATA_BITS + 1;

  localparam logic signed [RS_W-1:0] RND_SEC = RS_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [RS_W-1:0] DMAX_R  = RS_W'((2 ** (DATA_BITS - 1)) - 1);
  localparam logic signed [RS_W-1:0] DMIN_R  = -DMAX_R - RS_W'(1);
  localparam logic signed [FO_W-1:0] RND_OUT = FO_W'(1) <<< (DATA_FRAC - 1);
  localparam logic signed [FO_W-1:0] SMAX_R  = FO_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [FO_W-1:0] SMIN_R  = -SMAX_R - FO_W'(1);

  typedef enum logic [2:0] {S_IDLE, S_CH, S_TAP, S_DRAIN, S_SEC, S_FIN, S_OUT} state_t;

  state_t state;

  logic [NSEC_BITS-1:0] num_sections;
  logic [SEC_W-1:0]     nsec;
  logic [SEC_W-1:0]     sec;
  logic [CH_W-1:0]      ch;
  logic [TAP_W-1:0]     k;
  logic [CA_W-1:0]      cbase;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     rowbase;
  data_t                v;
  sample_t              smp   [IN_CHANNELS];
  sample_t              res   [IN_CHANNELS];
  sample_t              out_q [IN_CHANNELS];
  logic                 out_vld;

  // coefficient and history memories
  coef_t                coef_mem [NUM_COEFS];
  logic [NUM_COEFS-1:0] coef_vld;
  coef_t                coef_q;
  logic                 coef_q_vld;
  hist_t                hist_mem [NUM_ROWS];
  logic [NUM_ROWS-1:0]  hist_vld;
  hist_t                hist_q;
  logic                 hist_q_vld;

  logic                 coef_rd;
  logic [CA_W-1:0]      coef_addr;
  logic                 coef_wr;
  logic                 hist_rd;
  logic                 hist_wr;
  hist_t                hist_wdata;

  // mac pipeline
  logic                 s1_vld;
  logic [TAP_W-1:0]     s1_k;
  logic                 s2_vld;
  logic                 s2_neg;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  coef_t                coef_eff;
  hist_t                hist_eff;
  data_t                opnd;
  logic signed [RS_W-1:0] rs_t;
  logic signed [RS_W-1:0] rs_sh;
  data_t                y_sec;
  logic signed [FO_W-1:0] fo_t;
  logic signed [FO_W-1:0] fo_sh;
  sample_t              y_out;
  logic                 in_acc;

  assign samples.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign in_acc        = samples.valid && samples.ready;

  assign filtered.valid        = out_vld;
  assign filtered.filt_accel_x = out_q[0];
  assign filtered.filt_accel_y = out_q[1];
  assign filtered.filt_accel_z = out_q[2];
  assign filtered.filt_gyro_x  = out_q[3];
  assign filtered.filt_gyro_y  = out_q[4];
  assign filtered.filt_gyro_z  = out_q[5];

  assign coef_wr   = in_acc && (samples.opcode == OP_COEF) &&
                     (32'(samples.coef_index) < NUM_COEFS);
  assign coef_rd   = (state == S_TAP);
  assign coef_addr = CA_W'(cbase + CA_W'(k));
  assign hist_rd   = (state == S_TAP) && (k == TAP_B0);
  assign hist_wr   = (state == S_SEC);

  assign coef_eff = coef_q_vld ? coef_q : '0;
  assign hist_eff = hist_q_vld ? hist_q : '0;

  always_comb begin
    unique case (s1_k)
      TAP_B0:  opnd = v;
      TAP_B1:  opnd = hist_eff.x1;
      TAP_B2:  opnd = hist_eff.x2;
      TAP_A1:  opnd = hist_eff.y1;
      default: opnd = hist_eff.y2;
    endcase
  end

  // section result: round half up to 8 fraction bits, saturate to data width
  always_comb begin
    rs_t  = RS_W'(acc) + RND_SEC;
    rs_sh = rs_t >>> COEF_FRAC;
    if (rs_sh > DMAX_R) begin
      y_sec = DMAX_R[DATA_BITS-1:0];
    end else if (rs_sh < DMIN_R) begin
      y_sec = DMIN_R[DATA_BITS-1:0];
    end else begin
      y_sec = rs_sh[DATA_BITS-1:0];
    end
  end

  // channel result: round half up to integer, saturate to sample width
  always_comb begin
    fo_t  = FO_W'(v) + RND_OUT;
    fo_sh = fo_t >>> DATA_FRAC;
    if (fo_sh > SMAX_R) begin
      y_out = SMAX_R[SAMPLE_BITS-1:0];
    end else if (fo_sh < SMIN_R) begin
      y_out = SMIN_R[SAMPLE_BITS-1:0];
    end else begin
      y_out = fo_sh[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    hist_wdata.x1 = v;
    hist_wdata.x2 = hist_eff.x1;
    hist_wdata.y1 = y_sec;
    hist_wdata.y2 = hist_eff.y1;
  end

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[CA_W'(samples.coef_index)] <= samples.coef_value;
    end
    if (coef_rd) begin
      coef_q <= coef_mem[coef_addr];
    end
    if (hist_wr) begin
      hist_mem[row] <= hist_wdata;
    end
    if (hist_rd) begin
      hist_q <= hist_mem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld   <= '0;
      hist_vld   <= '0;
      coef_q_vld <= 1'b0;
      hist_q_vld <= 1'b0;
    end else begin
      if (coef_wr) begin
        coef_vld[CA_W'(samples.coef_index)] <= 1'b1;
      end
      if (in_acc && samples.opcode == OP_CLR) begin
        hist_vld <= '0;
      end else if (hist_wr) begin
        hist_vld[row] <= 1'b1;
      end
      if (coef_rd) begin
        coef_q_vld <= coef_vld[coef_addr];
      end
      if (hist_rd) begin
        hist_q_vld <= hist_vld[row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= coef_rd;
      s2_vld <= s1_vld;
    end
    s1_k   <= k;
    prod   <= coef_eff * opnd;
    s2_neg <= (s1_k == TAP_A1) || (s1_k == TAP_A2);
    if (state == S_TAP && k == TAP_B0) begin
      acc <= '0;
    end else if (s2_vld) begin
      acc <= s2_neg ? acc - ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sections <= '0;
    end else if (cfg.valid && cfg.ready) begin
      num_sections <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
      k       <= TAP_B0;
      sec     <= '0;
      ch      <= '0;
    end else begin
      if (filtered.valid && filtered.ready && state != S_OUT) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && samples.opcode == OP_FILT) begin
            smp[0]  <= samples.accel_x;
            smp[1]  <= samples.accel_y;
            smp[2]  <= samples.accel_z;
            smp[3]  <= samples.gyro_x;
            smp[4]  <= samples.gyro_y;
            smp[5]  <= samples.gyro_z;
            nsec    <= (32'(num_sections) > MAX_SECTIONS) ? SEC_W'(MAX_SECTIONS)
                                                          : SEC_W'(num_sections);
            for (int i = 0; i < IN_CHANNELS; i++) begin
              res[i] <= '0;
            end
            ch      <= '0;
            rowbase <= '0;
            state   <= S_CH;
          end
        end
        S_CH: begin
          v     <= data_t'(smp[ch]) <<< DATA_FRAC;
          sec   <= '0;
          cbase <= '0;
          row   <= rowbase;
          k     <= TAP_B0;
          state <= (nsec == '0) ? S_FIN : S_TAP;
        end
        S_TAP: begin
          if (k == TAP_A2) begin
            state <= S_DRAIN;
          end else begin
            k <= k + TAP_W'(1);
          end
        end
        S_DRAIN: begin
          if (!s1_vld) begin
            state <= S_SEC;
          end
        end
        S_SEC: begin
          v     <= y_sec;
          sec   <= sec + SEC_W'(1);
          cbase <= CA_W'(cbase + CA_W'(TAPS));
          row   <= row + ROW_W'(1);
          k     <= TAP_B0;
          state <= (sec + SEC_W'(1) == nsec) ? S_FIN : S_TAP;
        end
        S_FIN: begin
          res[ch] <= y_out;
          if (ch == CH_W'(USED_CH - 1)) begin
            state <= S_OUT;
          end else begin
            ch      <= ch + CH_W'(1);
            rowbase <= ROW_W'(rowbase + ROW_W'(MAX_SECTIONS));
            state   <= S_CH;
          end
        end
        S_OUT: begin
          if (!out_vld || filtered.ready) begin
            for (int i = 0; i < IN_CHANNELS; i++) begin
              out_q[i] <= res[i];
            end
            out_vld <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sim/six_axis_biquad_cascade_filter_tb.sv @@
// testbench for six_axis_biquad_cascade_filter: directed and random items, checked per axis
// against a fixed-point biquad cascade predictor kept in a scoreboard class
// depends on sixbq_pkg, the interfaces in sixbq_if and the filter top level
module six_axis_biquad_cascade_filter_tb;
  import sixbq_pkg::*;

  localparam int MAX_SEC       = 5;
  localparam int NUM_COEFS     = MAX_SEC * TAPS;
  localparam int LIMIT_CYCLES  = 1_500_000;
  localparam int HOLD_CYCLES   = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int NUM_PHASES    = 9;
  localparam int PHASE_ITEMS   = 90;

  localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef logic [IN_CHANNELS-1:0][SAMPLE_BITS-1:0] axes_t;

  typedef struct {
    logic [OPC_W-1:0]  opcode;
    axes_t             axes;
    logic [CIDX_W-1:0] coef_index;
    coef_t             coef_value;
  } imu_item_t;

  class filter_scoreboard;
    longint      coef_q [NUM_COEFS];
    longint      hist [IN_CHANNELS][MAX_SEC][4];  // x1 x2 y1 y2
    int unsigned active_sections;
    axes_t       expected [$];
    int          errors;
    int          results;
    int          filters;
    int          coef_writes;
    int          clears;

    function new();
      foreach (coef_q[i]) coef_q[i] = 0;
      clear_history();
      active_sections = 0;
      errors = 0;
      results = 0;
      filters = 0;
      coef_writes = 0;
      clears = 0;
    endfunction

    function void clear_history();
      foreach (hist[c, s, k]) hist[c][s][k] = 0;
    endfunction

    function void set_sections(int unsigned n);
      active_sections = (n > MAX_SEC) ? MAX_SEC : n;
    endfunction

    function longint round_clamp(longint v, int frac, int width);
      longint hi;
      longint r;
      hi = (longint'(1) <<< (width - 1)) - 1;
      r = (v + (longint'(1) <<< (frac - 1))) >>> frac;
      if (r > hi) r = hi;
      else if (r < -hi - 1) r = -hi - 1;
      return r;
    endfunction

    function longint run_stage(int ch, int sec, longint x);
      longint acc;
      longint y;
      int     base;
      base = sec * TAPS;
      acc = coef_q[base + TAP_B0] * x
          + coef_q[base + TAP_B1] * hist[ch][sec][0]
          + coef_q[base + TAP_B2] * hist[ch][sec][1]
          - coef_q[base + TAP_A1] * hist[ch][sec][2]
          - coef_q[base + TAP_A2] * hist[ch][sec][3];
      y = round_clamp(acc, COEF_FRAC, DATA_BITS);
      hist[ch][sec][1] = hist[ch][sec][0];
      hist[ch][sec][0] = x;
      hist[ch][sec][3] = hist[ch][sec][2];
      hist[ch][sec][2] = y;
      return y;
    endfunction

    function void note_item(imu_item_t it);
      axes_t  res;
      longint v;
      longint r;
      case (it.opcode)
        OP_COEF: begin
          coef_writes++;
          if (it.coef_index < NUM_COEFS) coef_q[it.coef_index] = longint'(it.coef_value);
        end
        OP_CLR: begin
          clears++;
          clear_history();
        end
        OP_FILT: begin
          filters++;
          for (int ch = 0; ch < IN_CHANNELS; ch++) begin
            v = longint'($signed(it.axes[ch]));
            v = v <<< DATA_FRAC;
            for (int s = 0; s < active_sections; s++) v = run_stage(ch, s, v);
            r = round_clamp(v, DATA_FRAC, SAMPLE_BITS);
            res[ch] = r[SAMPLE_BITS-1:0];
          end
          expected.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(axes_t got);
      axes_t want;
      results++;
      if (expected.size() == 0) begin
        report($sformatf("result %0d arrived with no filter item outstanding", results));
        return;
      end
      want = expected.pop_front();
      for (int i = 0; i < IN_CHANNELS; i++)
        if (got[i] !== want[i])
          report($sformatf("result %0d axis %0d got %0d want %0d", results, i,
                           $signed(got[i]), $signed(want[i])));
    endtask
  endclass

  logic clk;
  logic rst;
  logic hold_on;
  int   stall_pct;
  int   send_idle;
  int   cycles = 0;
  int   phase_sections [NUM_PHASES] = '{5, 2, 7, 0, 3, 6, 1, 4, 5};

  filter_scoreboard sb;

  sixbq_in_if  in_if ();
  sixbq_out_if out_if ();
  sixbq_cfg_if cfg_if ();

  six_axis_biquad_cascade_filter #(
    .MAX_SECTIONS(MAX_SEC),
    .NUM_CHANNELS(IN_CHANNELS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (in_if),
    .filtered (out_if),
    .cfg      (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_on) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    axes_t got;
    if (!rst && out_if.valid && out_if.ready) begin
      got[0] = out_if.filt_accel_x;
      got[1] = out_if.filt_accel_y;
      got[2] = out_if.filt_accel_z;
      got[3] = out_if.filt_gyro_x;
      got[4] = out_if.filt_gyro_y;
      got[5] = out_if.filt_gyro_z;
      sb.check_result(got);
    end
  end

  function automatic axes_t pack_axes(int ax, int ay, int az, int gx, int gy, int gz);
    axes_t a;
    a[0] = ax[SAMPLE_BITS-1:0];
    a[1] = ay[SAMPLE_BITS-1:0];
    a[2] = az[SAMPLE_BITS-1:0];
    a[3] = gx[SAMPLE_BITS-1:0];
    a[4] = gy[SAMPLE_BITS-1:0];
    a[5] = gz[SAMPLE_BITS-1:0];
    return a;
  endfunction

  function automatic axes_t random_axes();
    axes_t a;
    for (int i = 0; i < IN_CHANNELS; i++)
      case ($urandom_range(9))
        0: a[i] = 16'h7fff;
        1: a[i] = 16'h8000;
        default: a[i] = SAMPLE_BITS'($urandom);
      endcase
    return a;
  endfunction

  function automatic imu_item_t noise_item(logic [OPC_W-1:0] op);
    imu_item_t it;
    it.opcode     = op;
    it.axes       = random_axes();
    it.coef_index = CIDX_W'($urandom);
    it.coef_value = COEF_BITS'($urandom);
    return it;
  endfunction

  function automatic imu_item_t filt_item(axes_t a);
    imu_item_t it;
    it = noise_item(OP_FILT);
    it.axes = a;
    return it;
  endfunction

  function automatic imu_item_t coef_item(int idx, int val);
    imu_item_t it;
    it = noise_item(OP_COEF);
    it.coef_index = idx[CIDX_W-1:0];
    it.coef_value = val[COEF_BITS-1:0];
    return it;
  endfunction

  function automatic imu_item_t random_item();
    imu_item_t it;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 85) it = noise_item(OP_FILT);
    else if (pick < 92) it = noise_item(OP_COEF);
    else if (pick < 96) it = noise_item(OP_CLR);
    else it = noise_item(OP_SPARE);
    return it;
  endfunction

  task automatic send_item(input imu_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= it.opcode;
    in_if.accel_x    <= it.axes[0];
    in_if.accel_y    <= it.axes[1];
    in_if.accel_z    <= it.axes[2];
    in_if.gyro_x     <= it.axes[3];
    in_if.gyro_y     <= it.axes[4];
    in_if.gyro_z     <= it.axes[5];
    in_if.coef_index <= it.coef_index;
    in_if.coef_value <= it.coef_value;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(it);
  endtask

  task automatic write_num_sections(input int unsigned n);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= n[NSEC_BITS-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_sections(n);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      IDLE_NONE: begin send_idle = 0;  stall_pct <= 0;  end
      IDLE_SEND: begin send_idle = 78; stall_pct <= 0;  end
      IDLE_RECV: begin send_idle = 0;  stall_pct <= 78; end
      default:   begin send_idle = 8;  stall_pct <= 8;  end
    endcase
  endtask

  // stable sections have |a2| < 1 and |a1| < 1 + a2; noisy sets take any word
  task automatic load_coefs(input bit noisy);
    int a2;
    int a1_lim;
    for (int s = 0; s < MAX_SEC; s++) begin
      if (noisy) begin
        for (int k = 0; k < TAPS; k++) send_item(coef_item(s * TAPS + k, $urandom));
      end else begin
        a2 = $urandom_range(900000);
        a1_lim = 1048576 + a2 - 60000;
        send_item(coef_item(s * TAPS + TAP_B0, $urandom_range(300000)));
        send_item(coef_item(s * TAPS + TAP_B1, int'($urandom_range(600000)) - 300000));
        send_item(coef_item(s * TAPS + TAP_B2, int'($urandom_range(600000)) - 300000));
        send_item(coef_item(s * TAPS + TAP_A1, int'($urandom_range(2 * a1_lim)) - a1_lim));
        send_item(coef_item(s * TAPS + TAP_A2, a2));
      end
    end
  endtask

  initial begin
    sb = new();
    rst              <= 1'b1;
    hold_on          <= 1'b0;
    stall_pct        <= 0;
    send_idle         = 0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OP_FILT;
    in_if.accel_x    <= '0;
    in_if.accel_y    <= '0;
    in_if.accel_z    <= '0;
    in_if.gyro_x     <= '0;
    in_if.gyro_y     <= '0;
    in_if.gyro_z     <= '0;
    in_if.coef_index <= '0;
    in_if.coef_value <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // pass-through, ignored items and coefficient extremes
    write_num_sections(0);
    send_item(filt_item(pack_axes(32767, -32768, 0, -1, 1, 12345)));
    send_item(filt_item(pack_axes(-32768, 32767, -1, 0, -12345, 256)));
    send_item(noise_item(OP_SPARE));
    send_item(coef_item(31, 8388607));
    send_item(coef_item(NUM_COEFS, -8388608));
    send_item(coef_item(TAP_B0, 8388607));
    send_item(coef_item(TAP_B1, -8388608));
    send_item(coef_item(TAP_B2, 524288));
    send_item(coef_item(TAP_A1, -838861));
    send_item(coef_item(TAP_A2, 262144));
    send_item(filt_item(pack_axes(100, -100, 32767, -32768, 7, -7)));
    settle();

    // one section with saturating gain, then a clear
    write_num_sections(1);
    send_item(filt_item(pack_axes(32767, -32768, 0, -1, 1, 12345)));
    send_item(filt_item(pack_axes(-32768, 32767, 0, 0, 0, 0)));
    send_item(filt_item(pack_axes(0, 0, 0, 0, 0, 0)));
    send_item(noise_item(OP_CLR));
    send_item(filt_item(pack_axes(1, -1, 2, -2, 3, -3)));
    send_item(coef_item(NUM_COEFS - 1, $urandom));
    settle();

    // count above the maximum acts as the maximum
    write_num_sections(7);
    send_item(filt_item(pack_axes(32767, 32767, 32767, -32768, -32768, -32768)));
    send_item(filt_item(pack_axes(0, 1, -1, 2, -2, 3)));
    send_item(filt_item(random_axes()));
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_num_sections(phase_sections[p]);
      set_idling(p % 4);
      if (p == 0) begin
        fork
          begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
          end
        join_none
      end
      load_coefs(p % 3 == 2);
      send_item(noise_item(OP_CLR));
      repeat (PHASE_ITEMS) send_item(random_item());
      settle();
    end

    $display("checked %0d results from %0d filter items, with %0d coefficient writes and %0d clears",
             sb.results, sb.filters, sb.coef_writes, sb.clears);
    $display("section counts 0 to 7, four idle mixes and one long output hold were exercised");
    if (sb.errors == 0 && sb.expected.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
design/sixbq_pkg.sv
design/sixbq_if.sv
design/six_axis_biquad_cascade_filter.sv
sim/six_axis_biquad_cascade_filter_tb.sv
